### hdl/rcsm_pkg.sv
`timescale 1ns / 1ps

package rcsm_pkg;

   localparam int PULSE_W = 16;
   localparam int STEP_W  = 10;
   localparam int DB_W    = 19;
   localparam int DRIVE_W = 20;

   // Quotient of the map division never exceeds twice the step limit.
   localparam int QUO_W   = STEP_W + 1;
   localparam int NUM_W   = PULSE_W + QUO_W;
   localparam int MAP_W   = QUO_W + 1;
   localparam int SUM_W   = MAP_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_VERT_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND  = 3'd5;

   localparam logic [PULSE_W-1:0] VERT_MIN_RST   = 16'd1000;
   localparam logic [PULSE_W-1:0] VERT_MAX_RST   = 16'd2000;
   localparam logic [PULSE_W-1:0] HORIZ_MIN_RST  = 16'd1000;
   localparam logic [PULSE_W-1:0] HORIZ_MAX_RST  = 16'd2000;
   localparam logic [STEP_W-1:0]  STEP_LIMIT_RST = 10'd100;
   localparam logic [DB_W-1:0]    DEAD_BAND_RST  = 19'd0;

   // cos(pi/4) in Q30, rounded to nearest.
   localparam longint COS45_Q30 = 64'sd759250125;

   localparam int LANE_STAGES  = 14;
   localparam int MERGE_STAGES = 3;
   localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

   typedef logic [PULSE_W-1:0]        pulse_type;
   typedef logic [STEP_W-1:0]         step_type;
   typedef logic [DB_W-1:0]           dead_band_type;
   typedef logic signed [MAP_W-1:0]   mapped_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;
   typedef logic [LANE_STAGES-1:0]    lane_en_type;
   typedef logic [MERGE_STAGES-1:0]   merge_en_type;

   typedef enum logic [1:0] {
      SPAN_POS,
      SPAN_ZERO,
      SPAN_NEG
   } span_kind_type;

   typedef struct packed {
      pulse_type        rem;
      logic [QUO_W-1:0] nlo;
      logic [QUO_W-1:0] quo;
      pulse_type        span;
      span_kind_type    kind;
      step_type         lim;
   } div_stage_type;

endpackage

### hdl/rcsm_ifs.sv
`timescale 1ns / 1ps

interface rcsm_req_if;
   import rcsm_pkg::*;
   logic      valid;
   logic      ready;
   pulse_type vert_pulse;
   pulse_type horiz_pulse;
   logic      mix_enable;

   modport source (output valid, vert_pulse, horiz_pulse, mix_enable, input ready);
   modport sink   (input valid, vert_pulse, horiz_pulse, mix_enable, output ready);
endinterface

interface rcsm_rsp_if;
   import rcsm_pkg::*;
   logic      valid;
   logic      ready;
   drive_type left_drive;
   drive_type right_drive;
   logic      centered;

   modport source (output valid, left_drive, right_drive, centered, input ready);
   modport sink   (input valid, left_drive, right_drive, centered, output ready);
endinterface

interface rcsm_csr_if;
   import rcsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/rcsm_lane.sv
`timescale 1ns / 1ps

module rcsm_lane #(
   parameter int unsigned PULSE_TIMEOUT_US = 50000
) (
   input  logic                 clock,
   input  rcsm_pkg::lane_en_type en,
   input  rcsm_pkg::pulse_type  pulse,
   input  rcsm_pkg::pulse_type  lo,
   input  rcsm_pkg::pulse_type  hi,
   input  rcsm_pkg::step_type   lim,
   output rcsm_pkg::mapped_type result
);
   import rcsm_pkg::*;

   localparam int DIV_STEPS = QUO_W;

   pulse_type     p_tmo;
   pulse_type     p_lo;
   pulse_type     p_clamp;
   span_kind_type kind_in;

   pulse_type     off_ff;
   pulse_type     span_ff;
   span_kind_type kind_ff;
   step_type      lim_ff;

   logic [NUM_W-1:0] num;
   logic [PULSE_W:0] trial [DIV_STEPS];
   logic [PULSE_W:0] diff  [DIV_STEPS];
   div_stage_type    div_in [DIV_STEPS+1];
   div_stage_type    div_ff [DIV_STEPS+1];

   mapped_type res_in;
   mapped_type result_ff;

   // Entry stage: timeout, clamp to the window and classify the span.
   always_comb begin
      p_tmo   = (pulse > PULSE_W'(PULSE_TIMEOUT_US)) ? '0 : pulse;
      p_lo    = (p_tmo < lo) ? lo : p_tmo;
      p_clamp = (p_lo > hi) ? hi : p_lo;
      if (hi == lo) begin
         kind_in = SPAN_ZERO;
      end else if (hi < lo) begin
         kind_in = SPAN_NEG;
      end else begin
         kind_in = SPAN_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         off_ff  <= p_clamp - lo;
         span_ff <= hi - lo;
         kind_ff <= kind_in;
         lim_ff  <= lim;
      end
   end

   // The quotient fits QUO_W bits, so the upper numerator bits seed the remainder
   // and one restoring step per stage produces the rest.
   always_comb begin
      num = NUM_W'(off_ff) * NUM_W'({lim_ff, 1'b0});
      div_in[0].rem  = num[NUM_W-1:QUO_W];
      div_in[0].nlo  = num[QUO_W-1:0];
      div_in[0].quo  = '0;
      div_in[0].span = span_ff;
      div_in[0].kind = kind_ff;
      div_in[0].lim  = lim_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial[i] = {div_ff[i].rem, div_ff[i].nlo[QUO_W-1]};
         diff[i]  = trial[i] - {1'b0, div_ff[i].span};
         div_in[i+1]     = div_ff[i];
         div_in[i+1].nlo = {div_ff[i].nlo[QUO_W-2:0], 1'b0};
         if (trial[i] >= {1'b0, div_ff[i].span}) begin
            div_in[i+1].rem = diff[i][PULSE_W-1:0];
            div_in[i+1].quo = {div_ff[i].quo[QUO_W-2:0], 1'b1};
         end else begin
            div_in[i+1].rem = trial[i][PULSE_W-1:0];
            div_in[i+1].quo = {div_ff[i].quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
         if (en[i+1]) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   // An inverted window leaves the pulse at max, so the quotient is exactly
   // twice the limit and the result is plus the limit.
   always_comb begin
      case (div_ff[DIV_STEPS].kind)
         SPAN_ZERO: res_in = '0;
         SPAN_NEG:  res_in = $signed({2'b00, div_ff[DIV_STEPS].lim});
         SPAN_POS:  res_in = $signed({1'b0, div_ff[DIV_STEPS].quo})
                            - $signed({2'b00, div_ff[DIV_STEPS].lim});
         default:   res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[LANE_STAGES-1]) begin
         result_ff <= res_in;
      end
   end

   assign result = result_ff;

endmodule

### hdl/rcsm_merge.sv
`timescale 1ns / 1ps

module rcsm_merge #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  rcsm_pkg::merge_en_type  en,
   input  rcsm_pkg::mapped_type    x,
   input  rcsm_pkg::mapped_type    y,
   input  logic                    mix,
   input  rcsm_pkg::dead_band_type dead_band,
   output rcsm_pkg::drive_type     left_drive,
   output rcsm_pkg::drive_type     right_drive,
   output logic                    centered
);
   import rcsm_pkg::*;

   localparam int PROD_W = (SUM_W + FRAC_BITS + 1 > DRIVE_W + 1) ?
                           SUM_W + FRAC_BITS + 1 : DRIVE_W + 1;
   localparam longint COS45_FULL =
      (COS45_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   localparam logic [FRAC_BITS:0] COS45 = COS45_FULL[FRAC_BITS:0];
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(524287);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(524288);

   logic signed [SUM_W-1:0]  a_ff;
   logic signed [SUM_W-1:0]  b_ff;
   logic                     mix_ff;
   logic signed [PROD_W-1:0] l_in;
   logic signed [PROD_W-1:0] r_in;
   logic signed [PROD_W-1:0] l_ff;
   logic signed [PROD_W-1:0] r_ff;
   drive_type                left_in;
   drive_type                right_in;
   drive_type                left_ff;
   drive_type                right_ff;
   logic                     centered_ff;

   function automatic drive_type shape(input logic signed [PROD_W-1:0] v,
                                       input dead_band_type db);
      drive_type               s;
      logic signed [DRIVE_W:0] sx;
      logic [DRIVE_W:0]        mag;
      if (v > SAT_HI) begin
         s = DRIVE_W'(SAT_HI);
      end else if (v < SAT_LO) begin
         s = DRIVE_W'(SAT_LO);
      end else begin
         s = v[DRIVE_W-1:0];
      end
      sx  = {s[DRIVE_W-1], s};
      mag = sx[DRIVE_W] ? $unsigned(-sx) : $unsigned(sx);
      return (mag <= {2'b00, db}) ? '0 : s;
   endfunction

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff   <= mix ? SUM_W'(x) - SUM_W'(y) : SUM_W'(x);
         b_ff   <= mix ? SUM_W'(x) + SUM_W'(y) : SUM_W'(y);
         mix_ff <= mix;
      end
   end

   always_comb begin
      if (mix_ff) begin
         l_in = PROD_W'(a_ff) * $signed(PROD_W'(COS45));
         r_in = PROD_W'(b_ff) * $signed(PROD_W'(COS45));
      end else begin
         l_in = PROD_W'(a_ff) <<< FRAC_BITS;
         r_in = PROD_W'(b_ff) <<< FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         l_ff <= l_in;
         r_ff <= r_in;
      end
   end

   always_comb begin
      left_in  = shape(l_ff, dead_band);
      right_in = shape(r_ff, dead_band);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         centered_ff <= (left_in == '0) && (right_in == '0);
      end
   end

   assign left_drive  = left_ff;
   assign right_drive = right_ff;
   assign centered    = centered_ff;

endmodule

### hdl/rc_stick_mixer.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle until a rsp-side stall fills every stage; each lane divides with an
// 11-stage pipelined restoring divider, one quotient bit per stage; nothing is shared between items.
// A stall on the rsp side fills the bubbles first; req_ready drops only when every stage holds an item.
// Reset empties the pipeline and loads the configuration registers with their defaults.

module rc_stick_mixer #(
   parameter int unsigned PULSE_TIMEOUT_US = 50000,
   parameter int          FRAC_BITS        = 8
) (
   input logic        clock,
   input logic        reset,
   rcsm_req_if.sink   req_port,
   rcsm_rsp_if.source rsp_port,
   rcsm_csr_if.sink   csr_port
);
   import rcsm_pkg::*;

   pulse_type     vert_min_ff;
   pulse_type     vert_max_ff;
   pulse_type     horiz_min_ff;
   pulse_type     horiz_max_ff;
   step_type      step_limit_ff;
   dead_band_type dead_band_ff;

   logic [NUM_STAGES-1:0]  valid_ff;
   logic [NUM_STAGES-1:0]  valid_in;
   logic [NUM_STAGES-1:0]  adv;
   logic [LANE_STAGES-1:0] mix_ff;

   mapped_type x_map;
   mapped_type y_map;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vert_min_ff   <= VERT_MIN_RST;
         vert_max_ff   <= VERT_MAX_RST;
         horiz_min_ff  <= HORIZ_MIN_RST;
         horiz_max_ff  <= HORIZ_MAX_RST;
         step_limit_ff <= STEP_LIMIT_RST;
         dead_band_ff  <= DEAD_BAND_RST;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            CSR_VERT_MIN:   vert_min_ff   <= csr_port.data[PULSE_W-1:0];
            CSR_VERT_MAX:   vert_max_ff   <= csr_port.data[PULSE_W-1:0];
            CSR_HORIZ_MIN:  horiz_min_ff  <= csr_port.data[PULSE_W-1:0];
            CSR_HORIZ_MAX:  horiz_max_ff  <= csr_port.data[PULSE_W-1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_port.data[STEP_W-1:0];
            CSR_DEAD_BAND:  dead_band_ff  <= csr_port.data[DB_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or its contents move on this cycle.
   assign adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_port.ready;
   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign req_port.ready = adv[0];

   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_port.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The mix bit rides alongside the lanes to meet their results at the merge.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mix_ff[0] <= req_port.mix_enable;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
         if (adv[k]) begin
            mix_ff[k] <= mix_ff[k-1];
         end
      end
   end

   rcsm_lane #(
      .PULSE_TIMEOUT_US(PULSE_TIMEOUT_US)
   ) u_vert_lane (
      .clock  (clock),
      .en     (adv[LANE_STAGES-1:0]),
      .pulse  (req_port.vert_pulse),
      .lo     (vert_min_ff),
      .hi     (vert_max_ff),
      .lim    (step_limit_ff),
      .result (x_map)
   );

   rcsm_lane #(
      .PULSE_TIMEOUT_US(PULSE_TIMEOUT_US)
   ) u_horiz_lane (
      .clock  (clock),
      .en     (adv[LANE_STAGES-1:0]),
      .pulse  (req_port.horiz_pulse),
      .lo     (horiz_min_ff),
      .hi     (horiz_max_ff),
      .lim    (step_limit_ff),
      .result (y_map)
   );

   rcsm_merge #(
      .FRAC_BITS(FRAC_BITS)
   ) u_merge (
      .clock       (clock),
      .en          (adv[NUM_STAGES-1:LANE_STAGES]),
      .x           (x_map),
      .y           (y_map),
      .mix         (mix_ff[LANE_STAGES-1]),
      .dead_band   (dead_band_ff),
      .left_drive  (rsp_port.left_drive),
      .right_drive (rsp_port.right_drive),
      .centered    (rsp_port.centered)
   );

   assign rsp_port.valid = valid_ff[NUM_STAGES-1];

   a_centered_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.centered ==
         ((rsp_port.left_drive == '0) && (rsp_port.right_drive == '0))))
      else $error("centered flag disagrees with the drive commands");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_port.ready) |-> !req_port.ready)
      else $error("full pipeline accepted an item while the output stalled");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> (&valid_ff))
      else $error("input held off while the pipeline had an empty stage");

endmodule

### test/rcsm_drive_check.sv
`timescale 1ns / 1ps

module rcsm_drive_check #(
   parameter int unsigned PULSE_TIMEOUT_US = 50000,
   parameter int          FRAC_BITS        = 8
) (
   input  logic clock,
   input  logic reset,
   rcsm_req_if  req_bus,
   rcsm_rsp_if  rsp_bus,
   rcsm_csr_if  csr_bus,
   output int   errors,
   output int   results_seen
);
   import rcsm_pkg::*;

   localparam longint DRIVE_HI = (64'sd1 <<< (DRIVE_W - 1)) - 1;
   localparam longint DRIVE_LO = -(64'sd1 <<< (DRIVE_W - 1));
   // The rotation coefficient is cos(pi/4) rounded to nearest at the output precision.
   localparam longint COS45_Q  = (COS45_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

   typedef struct packed {
      drive_type left;
      drive_type right;
      logic      centered;
   } drive_cmd_type;

   pulse_type     vert_lo;
   pulse_type     vert_hi;
   pulse_type     horiz_lo;
   pulse_type     horiz_hi;
   step_type      step_lim;
   dead_band_type band;
   drive_cmd_type pending_cmds[$];

   initial begin
      errors       = 0;
      results_seen = 0;
   end

   function automatic longint map_stick(pulse_type pulse, pulse_type lo, pulse_type hi,
                                        step_type lim);
      longint p;
      longint lo_s;
      longint hi_s;
      longint full;
      p    = longint'(pulse);
      lo_s = longint'(lo);
      hi_s = longint'(hi);
      full = longint'(lim);
      // An overlong pulse counts as a timeout and then clamps to the minimum.
      if (p > longint'(PULSE_TIMEOUT_US)) p = 0;
      if (p < lo_s) p = lo_s;
      if (p > hi_s) p = hi_s;
      if (hi_s == lo_s) return 0;
      return (p - lo_s) * (2 * full) / (hi_s - lo_s) - full;
   endfunction

   function automatic drive_type limit_drive(longint v);
      longint mag;
      if (v > DRIVE_HI) v = DRIVE_HI;
      else if (v < DRIVE_LO) v = DRIVE_LO;
      mag = (v < 0) ? -v : v;
      if (mag <= longint'(band)) v = 0;
      return drive_type'(v);
   endfunction

   function automatic drive_cmd_type predict_drive(pulse_type vp, pulse_type hp, logic mix);
      longint x;
      longint y;
      longint l;
      longint r;
      drive_cmd_type cmd;
      x = map_stick(vp, vert_lo, vert_hi, step_lim);
      y = map_stick(hp, horiz_lo, horiz_hi, step_lim);
      if (mix) begin
         l = (x - y) * COS45_Q;
         r = (x + y) * COS45_Q;
      end else begin
         l = x * (64'sd1 <<< FRAC_BITS);
         r = y * (64'sd1 <<< FRAC_BITS);
      end
      cmd.left     = limit_drive(l);
      cmd.right    = limit_drive(r);
      cmd.centered = (cmd.left == 0) && (cmd.right == 0);
      return cmd;
   endfunction

   always @(posedge clock) begin : watch
      drive_cmd_type exp_cmd;
      if (reset) begin
         vert_lo  = VERT_MIN_RST;
         vert_hi  = VERT_MAX_RST;
         horiz_lo = HORIZ_MIN_RST;
         horiz_hi = HORIZ_MAX_RST;
         step_lim = STEP_LIMIT_RST;
         band     = DEAD_BAND_RST;
         pending_cmds.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_VERT_MIN:   vert_lo  = csr_bus.data[PULSE_W-1:0];
               CSR_VERT_MAX:   vert_hi  = csr_bus.data[PULSE_W-1:0];
               CSR_HORIZ_MIN:  horiz_lo = csr_bus.data[PULSE_W-1:0];
               CSR_HORIZ_MAX:  horiz_hi = csr_bus.data[PULSE_W-1:0];
               CSR_STEP_LIMIT: step_lim = csr_bus.data[STEP_W-1:0];
               CSR_DEAD_BAND:  band     = csr_bus.data[DB_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_cmds.push_back(predict_drive(req_bus.vert_pulse, req_bus.horiz_pulse,
                                                 req_bus.mix_enable));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen <= results_seen + 1;
            if (pending_cmds.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual left %0d right %0d c %0b",
                        $time, rsp_bus.left_drive, rsp_bus.right_drive, rsp_bus.centered);
            end else begin
               exp_cmd = pending_cmds.pop_front();
               if (rsp_bus.left_drive !== exp_cmd.left) begin
                  errors++;
                  $display("%0t: left_drive expected %0d, actual %0d",
                           $time, exp_cmd.left, rsp_bus.left_drive);
               end
               if (rsp_bus.right_drive !== exp_cmd.right) begin
                  errors++;
                  $display("%0t: right_drive expected %0d, actual %0d",
                           $time, exp_cmd.right, rsp_bus.right_drive);
               end
               if (rsp_bus.centered !== exp_cmd.centered) begin
                  errors++;
                  $display("%0t: centered expected %0b, actual %0b",
                           $time, exp_cmd.centered, rsp_bus.centered);
               end
            end
         end
      end
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rcsm_pkg::*;

   localparam int unsigned TIMEOUT_US        = 50000;
   localparam int          FRAC              = 8;
   localparam int          NUM_SETTINGS      = 11;
   localparam int          ITEMS_PER_SETTING = 60;
   localparam int          QUIET_LIMIT       = 5000;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {
      IDLE_NONE,
      IDLE_SOURCE,
      IDLE_SINK,
      IDLE_BOTH
   } idle_mode_type;

   logic      clock;
   logic      reset;
   int        src_idle_pct;
   int        sink_stall_pct;
   int        items_sent;
   int        settings_used;
   int        errors;
   int        results_seen;
   pulse_type win_vlo;
   pulse_type win_vhi;
   pulse_type win_hlo;
   pulse_type win_hhi;

   rcsm_req_if req_bus ();
   rcsm_rsp_if rsp_bus ();
   rcsm_csr_if csr_bus ();

   rc_stick_mixer #(
      .PULSE_TIMEOUT_US(TIMEOUT_US),
      .FRAC_BITS       (FRAC)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus),
      .csr_port(csr_bus)
   );

   rcsm_drive_check #(
      .PULSE_TIMEOUT_US(TIMEOUT_US),
      .FRAC_BITS       (FRAC)
   ) drive_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .errors      (errors),
      .results_seen(results_seen)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   task automatic set_idle(idle_mode_type mode);
      src_idle_pct = (mode == IDLE_SOURCE) ? 57 : (mode == IDLE_BOTH) ? 21 : 0;
      sink_stall_pct <= (mode == IDLE_SINK) ? 57 : (mode == IDLE_BOTH) ? 21 : 0;
   endtask

   task automatic send_item(pulse_type vp, pulse_type hp, logic mix);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.vert_pulse  <= vp;
      req_bus.horiz_pulse <= hp;
      req_bus.mix_enable  <= mix;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_setting(pulse_type vlo, pulse_type vhi, pulse_type hlo, pulse_type hhi,
                               step_type lim, dead_band_type db);
      write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom());
      write_reg(CSR_VERT_MIN, CSR_DATA_W'(vlo));
      write_reg(CSR_VERT_MAX, CSR_DATA_W'(vhi));
      write_reg(CSR_HORIZ_MIN, CSR_DATA_W'(hlo));
      write_reg(CSR_HORIZ_MAX, CSR_DATA_W'(hhi));
      write_reg(CSR_STEP_LIMIT, CSR_DATA_W'(lim));
      write_reg(CSR_DEAD_BAND, CSR_DATA_W'(db));
      csr_bus.valid <= 1'b0;
      win_vlo = vlo;
      win_vhi = vhi;
      win_hlo = hlo;
      win_hhi = hhi;
      settings_used++;
   endtask

   task automatic load_random_setting();
      int vlo;
      int vhi;
      int hlo;
      int hhi;
      int tmp;
      vlo = $urandom_range(TIMEOUT_US);
      vhi = $urandom_range(TIMEOUT_US);
      hlo = $urandom_range(TIMEOUT_US);
      hhi = $urandom_range(TIMEOUT_US);
      // Mostly ordered windows, with an inverted one now and then.
      if ($urandom_range(3) != 0 && vlo > vhi) begin
         tmp = vlo;
         vlo = vhi;
         vhi = tmp;
      end
      if ($urandom_range(3) != 0 && hlo > hhi) begin
         tmp = hlo;
         hlo = hhi;
         hhi = tmp;
      end
      load_setting(pulse_type'(vlo), pulse_type'(vhi), pulse_type'(hlo), pulse_type'(hhi),
                   step_type'($urandom_range(1023)),
                   dead_band_type'(($urandom_range(3) == 0) ? $urandom_range(524287)
                                                            : $urandom_range(3000)));
   endtask

   // Most pulses land in or near the window; the rest are timeouts and stray widths.
   function automatic pulse_type pick_pulse(pulse_type lo, pulse_type hi);
      int a;
      int b;
      int roll;
      a    = (lo < hi) ? int'(lo) : int'(hi);
      b    = (lo < hi) ? int'(hi) : int'(lo);
      roll = $urandom_range(99);
      if (roll < 6) return '0;
      if (roll < 11) return pulse_type'($urandom_range(65535, TIMEOUT_US + 1));
      if (roll < 18) return pulse_type'(roll[0] ? a : b);
      if (roll < 25) return pulse_type'($urandom_range(TIMEOUT_US));
      return pulse_type'($urandom_range((b + 200 > TIMEOUT_US) ? TIMEOUT_US : b + 200,
                                        (a > 200) ? a - 200 : 0));
   endfunction

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.vert_pulse  = '0;
      req_bus.horiz_pulse = '0;
      req_bus.mix_enable  = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      src_idle_pct        = 0;
      sink_stall_pct      = 0;
      items_sent          = 0;
      settings_used       = 0;
      win_vlo             = VERT_MIN_RST;
      win_vhi             = VERT_MAX_RST;
      win_hlo             = HORIZ_MIN_RST;
      win_hhi             = HORIZ_MAX_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed items against the reset window of 1000 to 2000 us.
      send_item(1500, 1500, 1'b0);
      send_item(1000, 1000, 1'b0);
      send_item(2000, 2000, 1'b0);
      send_item(0, 0, 1'b0);
      send_item(50000, 50000, 1'b0);
      send_item(50001, 65535, 1'b0);
      send_item(999, 2001, 1'b0);
      send_item(1001, 1999, 1'b0);
      send_item(1234, 1777, 1'b0);
      send_item(1499, 1501, 1'b0);
      send_item(1500, 1500, 1'b1);
      send_item(2000, 1000, 1'b1);
      send_item(1000, 2000, 1'b1);
      send_item(2000, 2000, 1'b1);
      send_item(1000, 1000, 1'b1);
      send_item(1500, 1750, 1'b1);
      send_item(1, 65534, 1'b1);
      send_item(32768, 16384, 1'b1);
      send_item(65535, 50000, 1'b1);
      send_item(21845, 43690, 1'b0);
      wait_drained();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         set_idle(idle_mode_type'(s % 4));
         case (s)
            0: load_setting(1000, 2000, 1000, 2000, 100, 0);
            1: load_setting(0, 50000, 0, 50000, 1023, 0);
            2: load_setting(2000, 1000, 1500, 1500, 512, 0);
            3: load_setting(1000, 2000, 1000, 2000, 0, 0);
            4: load_setting(1000, 2000, 1000, 2000, 1023, 524287);
            5: load_setting(1000, 2000, 1000, 2000, 1023, 20000);
            6: load_setting(1499, 1501, 0, 1, 1023, 0);
            7: load_setting(50000, 0, 0, 50000, 1023, 1);
            default: load_random_setting();
         endcase
         repeat (ITEMS_PER_SETTING) begin
            send_item(pick_pulse(win_vlo, win_vhi), pick_pulse(win_hlo, win_hhi),
                      1'($urandom_range(1)));
         end
         wait_drained();
      end

      repeat (2 * NUM_STAGES) @(posedge clock);
      $display("Ran %0d items over %0d register settings, mixed and pass-through,",
               items_sent, settings_used);
      $display("with timeouts, inverted and zero-span windows and dead bands up to full scale.");
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
